### design/bthalloc_pkg.sv
package bthalloc_pkg;

  // Operation codes carried in tuser.
  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_EXH  = 2'd2;
  localparam logic [1:0] STAT_NULL = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [1:0] CFG_INIT_CHUNK = 2'd1;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH,
    ST_I_W0, ST_I_W4, ST_I_W8, ST_I_W12, ST_I_CHK,
    ST_G_CHK, ST_G_W1, ST_G_W2, ST_G_W3,
    ST_M_R1, ST_M_R2, ST_M_R3, ST_M_R4, ST_M_R5, ST_M_DEC,
    ST_M_PA1, ST_M_PA2, ST_M_NA1, ST_M_NA2, ST_M_N1, ST_M_N2, ST_M_N3,
    ST_M_ROV, ST_M_END,
    ST_S_START, ST_S_CHK, ST_S_EVAL, ST_S_EXIT, ST_S_FAIL,
    ST_P_RD, ST_P_DEC, ST_P_SEL, ST_P_S1, ST_P_S2, ST_P_S3, ST_P_S4,
    ST_P_N1, ST_P_N2, ST_P_DONE,
    ST_F_RD, ST_F_W1, ST_F_W2,
    ST_FINISH
  } state_e;

  typedef enum logic [5:0] {
    C_NOP, C_ACCEPT, C_DISPATCH,
    C_I_W0, C_I_W4, C_I_W8, C_I_W12, C_I_CHK,
    C_G_CHK, C_G_W1, C_G_W2, C_G_W3,
    C_M_R1, C_M_R2, C_M_R3, C_M_R4, C_M_R5, C_M_DEC,
    C_M_PA1, C_M_PA2, C_M_NA1, C_M_NA2, C_M_N1, C_M_N2, C_M_N3,
    C_M_ROV,
    C_S_START, C_S_CHK, C_S_EVAL, C_S_EXIT, C_S_FAIL,
    C_P_RD, C_P_DEC, C_P_S1, C_P_S2, C_P_S3, C_P_S4,
    C_P_N1, C_P_N2, C_P_DONE,
    C_F_RD, C_F_W1, C_F_W2,
    C_FINISH
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic       req_zero;
    logic       top_zero;
    logic       free_ok;
    logic       chunk_zero;
    logic       grow_ovf;
    logic       cur_ok;
    logic       wrap_ok;
    logic       rd_zero;
    logic       rd_fit;
    logic       rd_alloc;
    logic       pa;
    logic       split_ok;
    logic       out_busy;
  } dp_status_t;

endpackage

### design/boundary_tag_heap_allocator_top.sv
// Boundary-tag heap allocator; one item is in flight at a time, so a new item can be
// accepted in the cycle after the previous result is loaded, and a result that is not
// taken holds the next one back. Init skips the heap growth for a zero chunk; an
// allocation visits blocks in turn, splits when it can, and grows the heap on a failed search.
// Reset clears control state only; the tag memory is not cleared and is laid out by init.
module boundary_tag_heap_allocator_top
  import bthalloc_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] request_bytes, [31:16] block_addr
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] payload_addr, [17:16] status, rest zero
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cmd_e        cmd;
  dp_status_t  st;
  logic [15:0] out_addr;
  logic [1:0]  out_status;

  // Registers are taken only while the controller is idle, between items.
  assign cfg_ready_o = s_axis_tready;

  // The controller steps the datapath through one operation; the datapath holds
  // the heap registers, the tag memory and the result register.
  bthalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bthalloc_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .op_i         (s_axis_tuser),
    .req_i        (s_axis_tdata[15:0]),
    .addr_i       (s_axis_tdata[31:16]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'd0, out_status, out_addr};

endmodule

### design/bthalloc_ctrl.sv
module bthalloc_ctrl
  import bthalloc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t st_i,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (st_i.op)
          OP_INIT:  state_d = ST_I_W0;
          OP_ALLOC: state_d = (st_i.req_zero || st_i.top_zero) ? ST_FINISH : ST_S_START;
          OP_FREE:  state_d = st_i.free_ok ? ST_F_RD : ST_FINISH;
          default:  state_d = ST_FINISH;
        endcase
      end
      ST_I_W0:  state_d = ST_I_W4;
      ST_I_W4:  state_d = ST_I_W8;
      ST_I_W8:  state_d = ST_I_W12;
      ST_I_W12: state_d = ST_I_CHK;
      ST_I_CHK: state_d = st_i.chunk_zero ? ST_FINISH : ST_G_CHK;
      ST_G_CHK: state_d = st_i.grow_ovf ? ST_FINISH : ST_G_W1;
      ST_G_W1:  state_d = ST_G_W2;
      ST_G_W2:  state_d = ST_G_W3;
      ST_G_W3:  state_d = ST_M_R1;
      ST_M_R1:  state_d = ST_M_R2;
      ST_M_R2:  state_d = ST_M_R3;
      ST_M_R3:  state_d = ST_M_R4;
      ST_M_R4:  state_d = ST_M_R5;
      ST_M_R5:  state_d = ST_M_DEC;
      ST_M_DEC: begin
        if (st_i.pa && st_i.rd_alloc) state_d = ST_M_END;
        else if (st_i.pa)             state_d = ST_M_PA1;
        else if (st_i.rd_alloc)       state_d = ST_M_NA1;
        else                          state_d = ST_M_N1;
      end
      ST_M_PA1: state_d = ST_M_PA2;
      ST_M_PA2: state_d = ST_M_ROV;
      ST_M_NA1: state_d = ST_M_NA2;
      ST_M_NA2: state_d = ST_M_ROV;
      ST_M_N1:  state_d = ST_M_N2;
      ST_M_N2:  state_d = ST_M_N3;
      ST_M_N3:  state_d = ST_M_ROV;
      ST_M_ROV: state_d = ST_M_END;
      ST_M_END: state_d = (st_i.op == OP_ALLOC) ? ST_P_RD : ST_FINISH;
      ST_S_START: state_d = ST_S_CHK;
      ST_S_CHK:   state_d = st_i.cur_ok ? ST_S_EVAL : ST_S_EXIT;
      ST_S_EVAL: begin
        if (st_i.rd_zero)     state_d = ST_S_EXIT;
        else if (st_i.rd_fit) state_d = ST_P_RD;
        else                  state_d = ST_S_CHK;
      end
      ST_S_EXIT: state_d = st_i.wrap_ok ? ST_S_CHK : ST_S_FAIL;
      ST_S_FAIL: state_d = ST_G_CHK;
      ST_P_RD:   state_d = ST_P_DEC;
      ST_P_DEC:  state_d = ST_P_SEL;
      ST_P_SEL:  state_d = st_i.split_ok ? ST_P_S1 : ST_P_N1;
      ST_P_S1:   state_d = ST_P_S2;
      ST_P_S2:   state_d = ST_P_S3;
      ST_P_S3:   state_d = ST_P_S4;
      ST_P_S4:   state_d = ST_P_DONE;
      ST_P_N1:   state_d = ST_P_N2;
      ST_P_N2:   state_d = ST_P_DONE;
      ST_P_DONE: state_d = ST_FINISH;
      ST_F_RD:   state_d = ST_F_W1;
      ST_F_W1:   state_d = ST_F_W2;
      ST_F_W2:   state_d = ST_M_R1;
      ST_FINISH: if (!st_i.out_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = C_NOP;
    case (state_q)
      ST_IDLE:     cmd_o = in_valid_i ? C_ACCEPT : C_NOP;
      ST_DISPATCH: cmd_o = C_DISPATCH;
      ST_I_W0:     cmd_o = C_I_W0;
      ST_I_W4:     cmd_o = C_I_W4;
      ST_I_W8:     cmd_o = C_I_W8;
      ST_I_W12:    cmd_o = C_I_W12;
      ST_I_CHK:    cmd_o = C_I_CHK;
      ST_G_CHK:    cmd_o = C_G_CHK;
      ST_G_W1:     cmd_o = C_G_W1;
      ST_G_W2:     cmd_o = C_G_W2;
      ST_G_W3:     cmd_o = C_G_W3;
      ST_M_R1:     cmd_o = C_M_R1;
      ST_M_R2:     cmd_o = C_M_R2;
      ST_M_R3:     cmd_o = C_M_R3;
      ST_M_R4:     cmd_o = C_M_R4;
      ST_M_R5:     cmd_o = C_M_R5;
      ST_M_DEC:    cmd_o = C_M_DEC;
      ST_M_PA1:    cmd_o = C_M_PA1;
      ST_M_PA2:    cmd_o = C_M_PA2;
      ST_M_NA1:    cmd_o = C_M_NA1;
      ST_M_NA2:    cmd_o = C_M_NA2;
      ST_M_N1:     cmd_o = C_M_N1;
      ST_M_N2:     cmd_o = C_M_N2;
      ST_M_N3:     cmd_o = C_M_N3;
      ST_M_ROV:    cmd_o = C_M_ROV;
      ST_S_START:  cmd_o = C_S_START;
      ST_S_CHK:    cmd_o = C_S_CHK;
      ST_S_EVAL:   cmd_o = C_S_EVAL;
      ST_S_EXIT:   cmd_o = C_S_EXIT;
      ST_S_FAIL:   cmd_o = C_S_FAIL;
      ST_P_RD:     cmd_o = C_P_RD;
      ST_P_DEC:    cmd_o = C_P_DEC;
      ST_P_S1:     cmd_o = C_P_S1;
      ST_P_S2:     cmd_o = C_P_S2;
      ST_P_S3:     cmd_o = C_P_S3;
      ST_P_S4:     cmd_o = C_P_S4;
      ST_P_N1:     cmd_o = C_P_N1;
      ST_P_N2:     cmd_o = C_P_N2;
      ST_P_DONE:   cmd_o = C_P_DONE;
      ST_F_RD:     cmd_o = C_F_RD;
      ST_F_W1:     cmd_o = C_F_W1;
      ST_F_W2:     cmd_o = C_F_W2;
      ST_FINISH:   cmd_o = C_FINISH;
      default:     cmd_o = C_NOP;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

`ifndef SYNTHESIS
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> state_q == ST_DISPATCH)
    else $error("accepted item did not reach dispatch");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !st_i.out_busy) |=> state_q == ST_IDLE)
    else $error("finished item did not release the controller");
  a_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_EVAL && !st_i.rd_zero && st_i.rd_fit) |=> state_q == ST_P_RD)
    else $error("fitting block was not placed");
`endif

endmodule

### design/bthalloc_dp.sv
module bthalloc_dp
  import bthalloc_pkg::*;
#(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_e        cmd_i,
  output dp_status_t  st_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] req_i,
  input  logic [15:0] addr_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_addr_o,
  output logic [1:0]  out_status_o
);

  localparam int CLG   = $clog2(HEAP_BYTES);
  localparam int AW    = (CLG + 2 > 18) ? CLG + 2 : 18;
  localparam int IW    = CLG - 2;
  localparam int DEPTH = HEAP_BYTES / 4;
  localparam logic [AW:0] HEAP_LIM = (AW + 1)'(HEAP_BYTES);

  logic [AW-1:0] mem [DEPTH];

  logic          policy_q, policy_d;
  logic [15:0]   chunk_q, chunk_d;
  logic [AW-1:0] top_q, top_d, rover_q, rover_d;
  logic          ovalid_q, ovalid_d;
  logic [15:0]   oaddr_q, oaddr_d;
  logic [1:0]    ostat_q, ostat_d;

  logic [1:0]    op_q, op_d;
  logic [15:0]   req_q, req_d, addr_q, addr_d, res_q, res_d;
  logic [1:0]    stat_q, stat_d;
  logic [AW-1:0] bp_q, bp_d, s_q, s_d, prev_q, prev_d, next_q, next_d;
  logic [AW-1:0] psz_q, psz_d, nsz_q, nsz_d, nf_q, nf_d, gsz_q, gsz_d;
  logic [AW-1:0] asize_q, asize_d, csize_q, csize_d, cur_q, cur_d, start_q, start_d;
  logic          pa_q, pa_d, phase_q, phase_d;
  logic [AW-1:0] rdata_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr, mem_wdata;
  logic [IW-1:0] mem_idx;

  logic [AW-1:0] rd_sz, chunk_rnd, asize_new;
  logic [16:0]   chunk_sum, req_sum;
  logic          out_busy;

  assign rd_sz     = {rdata_q[AW-1:3], 3'b000};
  assign chunk_sum = {1'b0, chunk_q} + 17'd7;
  assign chunk_rnd = AW'({chunk_sum[16:3], 3'b000});
  assign req_sum   = {1'b0, req_q} + 17'd15;
  assign asize_new = AW'({req_sum[16:3], 3'b000});
  assign mem_idx   = mem_addr[IW+1:2];
  assign out_busy  = ovalid_q && !out_ready_i;

  always_comb begin
    st_o.op         = op_q;
    st_o.req_zero   = (req_q == 16'd0);
    st_o.top_zero   = (top_q == '0);
    st_o.free_ok    = (top_q != '0) && (addr_q[2:0] == 3'd0) && (addr_q >= 16'd16)
                      && (AW'(addr_q) < top_q);
    st_o.chunk_zero = (chunk_rnd == '0);
    st_o.grow_ovf   = ({1'b0, top_q} + {1'b0, gsz_q}) > HEAP_LIM;
    st_o.cur_ok     = phase_q ? (cur_q < start_q && cur_q < top_q) : (cur_q < top_q);
    st_o.wrap_ok    = policy_q && !phase_q;
    st_o.rd_zero    = (rd_sz == '0);
    st_o.rd_fit     = !rdata_q[0] && (asize_q <= rd_sz);
    st_o.rd_alloc   = rdata_q[0];
    st_o.pa         = pa_q;
    st_o.split_ok   = (csize_q >= asize_q) && ((csize_q - asize_q) >= AW'(16));
    st_o.out_busy   = out_busy;
  end

  always_comb begin
    policy_d = policy_q;  chunk_d = chunk_q;  top_d = top_q;  rover_d = rover_q;
    ovalid_d = ovalid_q;  oaddr_d = oaddr_q;  ostat_d = ostat_q;
    op_d = op_q;  req_d = req_q;  addr_d = addr_q;  res_d = res_q;  stat_d = stat_q;
    bp_d = bp_q;  s_d = s_q;  prev_d = prev_q;  next_d = next_q;
    psz_d = psz_q;  nsz_d = nsz_q;  nf_d = nf_q;  gsz_d = gsz_q;
    asize_d = asize_q;  csize_d = csize_q;  cur_d = cur_q;  start_d = start_q;
    pa_d = pa_q;  phase_d = phase_q;
    mem_we = 1'b0;  mem_re = 1'b0;  mem_addr = '0;  mem_wdata = '0;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIT_POLICY: policy_d = cfg_data_i[0];
        CFG_INIT_CHUNK: chunk_d = cfg_data_i;
        default: ;
      endcase
    end

    case (cmd_i)
      C_ACCEPT: begin
        op_d = op_i;  req_d = req_i;  addr_d = addr_i;
        res_d = 16'd0;  stat_d = STAT_OK;
      end
      C_DISPATCH: begin
        bp_d = AW'(addr_q);
        case (op_q)
          OP_ALLOC: begin
            if (req_q == 16'd0)    stat_d = STAT_ZERO;
            else if (top_q == '0)  stat_d = STAT_EXH;
          end
          OP_FREE: if (addr_q == 16'd0) stat_d = STAT_NULL;
          default: ;
        endcase
      end
      C_I_W0:  begin mem_we = 1'b1; mem_addr = AW'(0);  mem_wdata = AW'(0); end
      C_I_W4:  begin mem_we = 1'b1; mem_addr = AW'(4);  mem_wdata = AW'(9); end
      C_I_W8:  begin mem_we = 1'b1; mem_addr = AW'(8);  mem_wdata = AW'(9); end
      C_I_W12: begin
        mem_we = 1'b1; mem_addr = AW'(12); mem_wdata = AW'(1);
        top_d = AW'(16);  rover_d = AW'(8);
      end
      C_I_CHK: gsz_d = chunk_rnd;
      C_G_CHK: if (({1'b0, top_q} + {1'b0, gsz_q}) > HEAP_LIM) stat_d = STAT_EXH;
      C_G_W1: begin
        mem_we = 1'b1; mem_addr = top_q - AW'(4); mem_wdata = gsz_q;
        bp_d = top_q;
      end
      C_G_W2: begin mem_we = 1'b1; mem_addr = bp_q + gsz_q - AW'(8); mem_wdata = gsz_q; end
      C_G_W3: begin
        mem_we = 1'b1; mem_addr = bp_q + gsz_q - AW'(4); mem_wdata = AW'(1);
        top_d = top_q + gsz_q;
      end
      C_M_R1: begin mem_re = 1'b1; mem_addr = bp_q - AW'(8); end
      C_M_R2: begin
        prev_d = bp_q - rd_sz;
        mem_re = 1'b1; mem_addr = bp_q - AW'(4);
      end
      C_M_R3: begin
        s_d = rd_sz;  next_d = bp_q + rd_sz;
        mem_re = 1'b1; mem_addr = prev_q - AW'(4);
      end
      C_M_R4: begin
        psz_d = rd_sz;
        mem_re = 1'b1; mem_addr = prev_q + rd_sz - AW'(8);
      end
      C_M_R5: begin
        pa_d = rdata_q[0];
        mem_re = 1'b1; mem_addr = next_q - AW'(4);
      end
      C_M_DEC: nsz_d = rd_sz;
      C_M_PA1: begin
        s_d = s_q + nsz_q;
        mem_we = 1'b1; mem_addr = bp_q - AW'(4); mem_wdata = s_q + nsz_q;
      end
      C_M_PA2: begin mem_we = 1'b1; mem_addr = bp_q + s_q - AW'(8); mem_wdata = s_q; end
      C_M_NA1: begin
        s_d = s_q + psz_q;
        mem_we = 1'b1; mem_addr = bp_q + s_q - AW'(8); mem_wdata = s_q + psz_q;
      end
      C_M_NA2: begin
        mem_we = 1'b1; mem_addr = prev_q - AW'(4); mem_wdata = s_q;
        bp_d = prev_q;
      end
      C_M_N1: begin
        nf_d = next_q + nsz_q - AW'(8);
        mem_re = 1'b1; mem_addr = next_q + nsz_q - AW'(8);
      end
      C_M_N2: begin
        s_d = s_q + psz_q + rd_sz;
        mem_we = 1'b1; mem_addr = prev_q - AW'(4); mem_wdata = s_q + psz_q + rd_sz;
      end
      C_M_N3: begin
        mem_we = 1'b1; mem_addr = nf_q; mem_wdata = s_q;
        bp_d = prev_q;
      end
      C_M_ROV: begin
        // Pull the rover back when it points inside the merged block.
        if (rover_q > bp_q &&
            {1'b0, rover_q} < ({1'b0, bp_q} + {1'b0, s_q[AW-1:3], 3'b000}))
          rover_d = bp_q;
      end
      C_S_START: begin
        asize_d = asize_new;
        cur_d   = policy_q ? rover_q : AW'(8);
        start_d = rover_q;
        phase_d = 1'b0;
      end
      C_S_CHK: begin mem_re = 1'b1; mem_addr = cur_q - AW'(4); end
      C_S_EVAL: begin
        if (rd_sz != '0) begin
          if (!rdata_q[0] && asize_q <= rd_sz) begin
            bp_d = cur_q;
            if (policy_q) rover_d = cur_q;
          end else begin
            cur_d = cur_q + rd_sz;
          end
        end
      end
      C_S_EXIT: begin
        if (policy_q && !phase_q) begin
          cur_d = AW'(8);  phase_d = 1'b1;
        end
      end
      C_S_FAIL: begin
        if (policy_q) rover_d = cur_q;
        gsz_d = asize_q;
      end
      C_P_RD:  begin mem_re = 1'b1; mem_addr = bp_q - AW'(4); end
      C_P_DEC: csize_d = rd_sz;
      C_P_S1: begin
        mem_we = 1'b1; mem_addr = bp_q - AW'(4); mem_wdata = asize_q | AW'(1);
      end
      C_P_S2: begin
        mem_we = 1'b1; mem_addr = bp_q + asize_q - AW'(8); mem_wdata = asize_q | AW'(1);
      end
      C_P_S3: begin
        mem_we = 1'b1; mem_addr = bp_q + asize_q - AW'(4); mem_wdata = csize_q - asize_q;
      end
      C_P_S4: begin
        mem_we = 1'b1; mem_addr = bp_q + csize_q - AW'(8); mem_wdata = csize_q - asize_q;
      end
      C_P_N1: begin
        mem_we = 1'b1; mem_addr = bp_q - AW'(4); mem_wdata = csize_q | AW'(1);
      end
      C_P_N2: begin
        mem_we = 1'b1; mem_addr = bp_q + csize_q - AW'(8); mem_wdata = csize_q | AW'(1);
      end
      C_P_DONE: res_d = bp_q[15:0];
      C_F_RD:  begin mem_re = 1'b1; mem_addr = bp_q - AW'(4); end
      C_F_W1: begin
        s_d = rd_sz;
        mem_we = 1'b1; mem_addr = bp_q - AW'(4); mem_wdata = rd_sz;
      end
      C_F_W2: begin mem_we = 1'b1; mem_addr = bp_q + s_q - AW'(8); mem_wdata = s_q; end
      C_FINISH: begin
        if (!out_busy) begin
          ovalid_d = 1'b1;  oaddr_d = res_q;  ostat_d = stat_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b1;
      chunk_q  <= 16'd4096;
      top_q    <= '0;
      rover_q  <= AW'(8);
      ovalid_q <= 1'b0;
    end else begin
      policy_q <= policy_d;
      chunk_q  <= chunk_d;
      top_q    <= top_d;
      rover_q  <= rover_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oaddr_q <= oaddr_d;  ostat_q <= ostat_d;
    op_q <= op_d;  req_q <= req_d;  addr_q <= addr_d;  res_q <= res_d;  stat_q <= stat_d;
    bp_q <= bp_d;  s_q <= s_d;  prev_q <= prev_d;  next_q <= next_d;
    psz_q <= psz_d;  nsz_q <= nsz_d;  nf_q <= nf_d;  gsz_q <= gsz_d;
    asize_q <= asize_d;  csize_q <= csize_d;  cur_q <= cur_d;  start_q <= start_d;
    pa_q <= pa_d;  phase_q <= phase_d;
  end

  // Single-port tag memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_idx] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_idx];
  end

  assign out_valid_o  = ovalid_q;
  assign out_addr_o   = oaddr_q;
  assign out_status_o = ostat_q;

endmodule

### dv/tb_boundary_tag_heap_allocator_top.sv
`timescale 1ns / 100ps

module tb_boundary_tag_heap_allocator_top;
  import bthalloc_pkg::*;

  localparam int unsigned HEAP_SIZE  = 65536;
  localparam int unsigned TAG_DEPTH  = HEAP_SIZE / 4;
  localparam int unsigned FIRST_BP   = 8;
  localparam int unsigned SPLIT_MIN  = 16;
  localparam int unsigned IDLE_LIMIT = 50000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    logic [15:0] payload_addr;
    logic [1:0]  status;
  } alloc_result_t;

  // Scoreboard: keeps a copy of the allocator state, predicts the result of
  // every accepted item and compares results in order.
  class heap_scoreboard;
    int unsigned   tags[TAG_DEPTH];
    int unsigned   heap_top;
    int unsigned   rover;
    bit            rover_fit;
    int unsigned   chunk_bytes;
    alloc_result_t pending[$];
    logic [15:0]   live_blocks[$];
    int            errors;
    int            n_alloc_ok, n_exhausted, n_merged_frees, n_inits;

    function void reset_state();
      heap_top    = 0;
      rover       = FIRST_BP;
      rover_fit   = 1'b1;
      chunk_bytes = 4096;
    endfunction

    function void configure(logic [1:0] idx, logic [15:0] data);
      if (idx == CFG_FIT_POLICY) rover_fit = data[0];
      else if (idx == CFG_INIT_CHUNK) chunk_bytes = 32'(data);
    endfunction

    function int unsigned rd(int unsigned a);
      return tags[(a >> 2) % TAG_DEPTH];
    endfunction
    function void wr(int unsigned a, int unsigned v);
      tags[(a >> 2) % TAG_DEPTH] = v;
    endfunction
    function int unsigned sz_at(int unsigned a);
      return rd(a) & ~32'h7;
    endfunction
    function int unsigned bsize(int unsigned bp);
      return sz_at(bp - 4);
    endfunction
    function void tag_block(int unsigned bp, int unsigned size, int unsigned a);
      wr(bp - 4, size | a);
      wr(bp + size - 8, size | a);
    endfunction

    // Merges a free block with free neighbours and returns the merged start.
    function int unsigned coalesce(int unsigned bp);
      int unsigned prv, nxt, s, nf;
      bit pa, na;
      prv = bp - sz_at(bp - 8);
      nxt = bp + bsize(bp);
      pa  = 1'(rd(prv + bsize(prv) - 8) & 1);
      na  = 1'(rd(nxt - 4) & 1);
      s   = bsize(bp);
      if (pa && na) return bp;
      if (pa) begin
        s += bsize(nxt);
        tag_block(bp, s, 0);
      end else if (na) begin
        wr(bp + s - 8, s + bsize(prv));
        s += bsize(prv);
        wr(prv - 4, s);
        bp = prv;
      end else begin
        nf = nxt + bsize(nxt) - 8;
        s += bsize(prv) + sz_at(nf);
        wr(prv - 4, s);
        wr(nf, s);
        bp = prv;
      end
      if (rover > bp && rover < bp + bsize(bp)) rover = bp;
      return bp;
    endfunction

    function bit extend(int unsigned size, output int unsigned bp);
      bp = heap_top;
      if (longint'(heap_top) + size > HEAP_SIZE) return 0;
      wr(bp - 4, size);
      wr(bp + size - 8, size);
      wr(bp + size - 4, 1);
      heap_top += size;
      bp = coalesce(bp);
      return 1;
    endfunction

    function bit fits(int unsigned bp, int unsigned asize);
      return !(rd(bp - 4) & 1) && asize <= bsize(bp);
    endfunction

    function bit find_free(int unsigned asize, output int unsigned bp);
      int unsigned start;
      bp = 0;
      if (rover_fit) begin
        start = rover;
        while (rover < heap_top && bsize(rover) > 0) begin
          if (fits(rover, asize)) begin bp = rover; return 1; end
          rover = rover + bsize(rover);
        end
        rover = FIRST_BP;
        while (rover < start && rover < heap_top && bsize(rover) > 0) begin
          if (fits(rover, asize)) begin bp = rover; return 1; end
          rover = rover + bsize(rover);
        end
        return 0;
      end
      for (int unsigned b = FIRST_BP; b < heap_top && bsize(b) > 0; b = b + bsize(b))
        if (fits(b, asize)) begin bp = b; return 1; end
      return 0;
    endfunction

    function void carve(int unsigned bp, int unsigned asize);
      int unsigned csize;
      csize = bsize(bp);
      if (csize >= asize && csize - asize >= SPLIT_MIN) begin
        tag_block(bp, asize, 1);
        tag_block(bp + asize, csize - asize, 0);
      end else begin
        tag_block(bp, csize, 1);
      end
    endfunction

    // Called for each accepted input item.
    function void note_input(logic [1:0] op, logic [15:0] req, logic [15:0] addr);
      alloc_result_t r;
      int unsigned bp, asize, chunk;
      r = '0;
      if (op == OP_INIT) begin
        n_inits++;
        chunk = (chunk_bytes + 7) & ~32'h7;
        wr(0, 0); wr(4, 9); wr(8, 9); wr(12, 1);
        heap_top = 16;
        rover    = FIRST_BP;
        live_blocks.delete();
        if (chunk > 0 && !extend(chunk, bp)) r.status = STAT_EXH;
      end else if (op == OP_ALLOC) begin
        if (req == 0) r.status = STAT_ZERO;
        else if (heap_top == 0) r.status = STAT_EXH;
        else begin
          asize = ((req + 15) / 8) * 8;
          if (find_free(asize, bp) || extend(asize, bp)) begin
            carve(bp, asize);
            r.payload_addr = bp[15:0];
            live_blocks.push_back(bp[15:0]);
            n_alloc_ok++;
          end else begin
            r.status = STAT_EXH;
          end
        end
        if (r.status == STAT_EXH) n_exhausted++;
      end else if (op == OP_FREE) begin
        if (addr == 0) r.status = STAT_NULL;
        else if (heap_top != 0 && addr[2:0] == 0 && addr >= 16 && addr < heap_top) begin
          tag_block(addr, bsize(addr), 0);
          void'(coalesce(addr));
          n_merged_frees++;
          foreach (live_blocks[i])
            if (live_blocks[i] == addr) begin live_blocks.delete(i); break; end
        end
      end
      pending.push_back(r);
    endfunction

    // Called for each accepted result item.
    function void check_result(logic [23:0] data);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[15:0] !== e.payload_addr) begin
        $error("payload_addr: expected %0d, got %0d", e.payload_addr, data[15:0]);
        errors++;
      end
      if (data[17:16] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, data[17:16]);
        errors++;
      end
      if (data[23:18] !== 6'd0) begin
        $error("padding: expected 0, got %h", data[23:18]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i, cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  heap_scoreboard sb;
  int  n_sent, n_received, idle_cycles;
  bit  quiet;      // no random idling on either side while set
  bit  stim_done;

  boundary_tag_heap_allocator_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Sends one item; valid stays high so back-to-back items need no gap.
  task automatic send_item(logic [1:0] op, logic [15:0] req, logic [15:0] addr);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {addr, req};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, req, addr);
    n_sent++;
    if (!quiet && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  // Lowers valid, then waits for all results and lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.configure(idx, data);
    @(posedge clk_i);
  endtask

  task automatic setup(bit policy, logic [15:0] chunk);
    drain();
    write_reg(CFG_FIT_POLICY, {15'd0, policy});
    write_reg(CFG_INIT_CHUNK, chunk);
  endtask

  // Mostly small requests, a few large ones; frees of live blocks, and some
  // null or misaligned frees, zero-size requests, unused ops and inits as noise.
  task automatic random_item();
    int unsigned pick, idx;
    logic [15:0] req, junk;
    pick = $urandom_range(99);
    junk = 16'($urandom);
    if (pick < 55) begin
      case ($urandom_range(99)) inside
        [0:69]:  req = 16'($urandom_range(64, 1));
        [70:89]: req = 16'($urandom_range(1024, 65));
        [90:96]: req = 16'($urandom_range(8192, 1025));
        default: req = 16'($urandom);
      endcase
      send_item(OP_ALLOC, req, junk);
    end else if (pick < 88 && sb.live_blocks.size() != 0) begin
      idx = $urandom_range(sb.live_blocks.size() - 1);
      send_item(OP_FREE, junk, sb.live_blocks[idx]);
    end else if (pick < 91) begin
      send_item(OP_FREE, junk, 16'd0);
    end else if (pick < 94) begin
      send_item(OP_FREE, junk, junk | 16'h1);
    end else if (pick < 96) begin
      send_item(OP_ALLOC, 16'd0, junk);
    end else if (pick < 98) begin
      send_item(OP_UNUSED, junk, 16'($urandom));
    end else begin
      send_item(OP_INIT, junk, 16'($urandom));
    end
  endtask

  // Receiver: random stalls, one long hold-off that fills the block up.
  initial begin
    int hold;
    bit held_once;
    hold = 0;
    held_once = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        n_received++;
      end
      if (!held_once && n_received == 300) begin
        held_once = 1;
        hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 16);
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
        $display("boundary_tag_heap_allocator_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int wait_cycles;
    sb = new;
    sb.reset_state();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_INIT;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FIT_POLICY;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    stim_done     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ops before init, then the field extremes with the reset settings.
    send_item(OP_ALLOC, 16'd5, 16'd0);
    send_item(OP_FREE, 16'd0, 16'd40);
    send_item(OP_FREE, 16'hFFFF, 16'd0);
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(OP_INIT, 16'd0, 16'd0);
    send_item(OP_ALLOC, 16'd0, 16'hFFFF);
    send_item(OP_ALLOC, 16'd1, 16'd0);
    send_item(OP_ALLOC, 16'hFFFF, 16'd0);
    send_item(OP_ALLOC, 16'd100, 16'd0);
    send_item(OP_FREE, 16'd0, 16'hFFFF);
    send_item(OP_FREE, 16'd0, 16'd8);
    send_item(OP_FREE, 16'd0, sb.heap_top[15:0]);
    send_item(OP_FREE, 16'd0, sb.live_blocks[0]);
    send_item(OP_ALLOC, 16'd4000, 16'd0);
    send_item(OP_ALLOC, 16'd200, 16'd0);
    send_item(OP_FREE, 16'd0, sb.live_blocks[1]);
    send_item(OP_INIT, 16'd0, 16'd0);  // repeated init
    // Empty heap, first fit: allocations grow the heap, and the last one reuses a freed block.
    setup(1'b0, 16'd0);
    send_item(OP_INIT, 16'd0, 16'd0);
    send_item(OP_ALLOC, 16'd8, 16'd0);
    send_item(OP_ALLOC, 16'd24, 16'd0);
    send_item(OP_FREE, 16'd0, sb.live_blocks[0]);
    send_item(OP_ALLOC, 16'd3, 16'd0);
    // Chunk too large for the heap.
    setup(1'b1, 16'hFFF8);
    send_item(OP_INIT, 16'd0, 16'd0);
    send_item(OP_ALLOC, 16'd60000, 16'd0);

    // Random phases over several settings, each starting from a fresh heap.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: setup(1'b1, 16'd4096);
        1: setup(1'b0, 16'd8);
        2: setup(1'b1, 16'd32768);
        3: setup(1'b0, 16'd1001);
        default: setup(1'b1, 16'd8);
      endcase
      send_item(OP_INIT, 16'($urandom), 16'($urandom));
      for (int i = 0; i < 105; i++) begin
        quiet = (ph == 1) && (i >= 30) && (i < 90);
        random_item();
      end
      quiet = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);

    $display("Sent %0d items (%0d inits), %0d results; %0d allocations placed,",
             n_sent, sb.n_inits, n_received, sb.n_alloc_ok);
    $display("%0d exhausted, %0d frees applied under both fit policies.",
             sb.n_exhausted, sb.n_merged_frees);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("boundary_tag_heap_allocator_top regression: pass");
    else
      $display("boundary_tag_heap_allocator_top regression: fail");
    $finish;
  end

endmodule

### files.f
design/bthalloc_pkg.sv
design/bthalloc_ctrl.sv
design/bthalloc_dp.sv
design/boundary_tag_heap_allocator_top.sv
dv/tb_boundary_tag_heap_allocator_top.sv
